// File: src/sffu_pkg.sv
// Shared types, codes and constants for the serial frame field unpacker.
package sffu_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAME_W   = 3 * WORD_W;
  localparam int POS_W     = 8;
  localparam int LEN_W     = 7;
  localparam int TYPE_W    = 4;
  localparam int SLOT_IN_W = 4;
  localparam int RAW_W     = 64;
  localparam int CNT_W     = 32;

  localparam int SLOT_CODES          = 1 << SLOT_IN_W;
  localparam int COUNTER_SLOTS_DEF   = 16;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Field type codes
  localparam logic [TYPE_W-1:0] TYPE_BITS     = 4'd1;
  localparam logic [TYPE_W-1:0] TYPE_UNSIGNED = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_SIGNED   = 4'd3;
  localparam logic [TYPE_W-1:0] TYPE_STREAM   = 4'd6;
  localparam logic [TYPE_W-1:0] TYPE_BOOL     = 4'd7;
  localparam logic [TYPE_W-1:0] TYPE_COUNTER  = 4'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TYPE = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_t;

  // What the back end does with a field beyond extraction
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_FRAC  = 2'd1,
    KIND_COUNT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [FRAME_W-1:0]   frame;
    logic [POS_W-1:0]     pos;
    logic [LEN_W-1:0]     len;
    kind_t                kind;
    status_t              status;
    logic [SLOT_IN_W-1:0] slot;   // already folded into the slot range
  } item_t;

  // Slot code -> slot index, i.e. code modulo n, built at elaboration.
  function automatic logic [SLOT_CODES*SLOT_IN_W-1:0] slot_map(int n);
    logic [SLOT_CODES*SLOT_IN_W-1:0] map;
    int v;
    map = '0;
    for (int i = 0; i < SLOT_CODES; i++) begin
      v = i;
      for (int k = 0; k < SLOT_CODES; k++) begin
        if (v >= n) begin
          v = v - n;
        end
      end
      map[i*SLOT_IN_W +: SLOT_IN_W] = SLOT_IN_W'(v);
    end
    return map;
  endfunction

endpackage

// File: src/serial_frame_field_unpacker_unit.sv
// Top level of the serial frame field unpacker: front end, queue, back end.
//
//   channel | signals                                   | beat moves when
//   --------+-------------------------------------------+----------------------------
//   in      | in_valid / in_stall, frame_word0..2,      | in_valid && !in_stall
//           | first_field, write_only, field_length,    |
//           | field_type, counter_slot                  |
//   out     | out_valid / out_stall, raw_value,         | out_valid && !out_stall
//           | flag_value, signed_fraction,              |
//           | counter_total, status                     |
//
// One field beat per cycle sustained while out_stall stays low; a read field
// reaches the output through the queue entry, the extraction register and the
// output register. Write-only beats only touch the bit position.
// The counter read-modify-write sits in the last stage, so back-to-back
// beats on the same slot need no forwarding.
// Synchronous reset clears bit position and all counter slots at once;
// there is no clearing pass.
// Output stalls back up through the output and extraction registers into
// the two-entry queue; in_stall rises only when the queue is full.
module serial_frame_field_unpacker_unit #(
  parameter int COUNTER_SLOTS = sffu_pkg::COUNTER_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sffu_pkg::WORD_W-1:0]       frame_word0,
  input  logic [sffu_pkg::WORD_W-1:0]       frame_word1,
  input  logic [sffu_pkg::WORD_W-1:0]       frame_word2,
  input  logic                              first_field,
  input  logic                              write_only,
  input  logic [sffu_pkg::LEN_W-1:0]        field_length,
  input  logic [sffu_pkg::TYPE_W-1:0]       field_type,
  input  logic [sffu_pkg::SLOT_IN_W-1:0]    counter_slot,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sffu_pkg::RAW_W-1:0]        raw_value,
  output logic                              flag_value,
  output logic signed [sffu_pkg::CNT_W-1:0] signed_fraction,
  output logic signed [sffu_pkg::CNT_W-1:0] counter_total,
  output logic [1:0]                        status
);

  // front -> queue
  logic            q_push;
  sffu_pkg::item_t q_in_item;
  logic            q_full;

  // queue -> back
  logic            q_valid;
  sffu_pkg::item_t q_out_item;
  logic            q_ready;

  // Position tracking and type/length checks happen at the input beat.
  sffu_front #(
    .COUNTER_SLOTS (COUNTER_SLOTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_word0  (frame_word0),
    .frame_word1  (frame_word1),
    .frame_word2  (frame_word2),
    .first_field  (first_field),
    .write_only   (write_only),
    .field_length (field_length),
    .field_type   (field_type),
    .counter_slot (counter_slot),
    .q_push       (q_push),
    .q_item       (q_in_item),
    .q_full       (q_full)
  );

  // Decouples input acceptance from output back-pressure.
  sffu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_out_item),
    .pop_ready (q_ready)
  );

  // Barrel extraction, then fraction and counter unwrap into the output register.
  sffu_back #(
    .COUNTER_SLOTS (COUNTER_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_out_item),
    .q_ready         (q_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .raw_value       (raw_value),
    .flag_value      (flag_value),
    .signed_fraction (signed_fraction),
    .counter_total   (counter_total),
    .status          (status)
  );

endmodule

// File: src/sffu_front.sv
// Front end: accepts field beats, tracks bit position, classifies, pushes to the queue.
module sffu_front #(
  parameter int COUNTER_SLOTS = sffu_pkg::COUNTER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sffu_pkg::WORD_W-1:0]     frame_word0,
  input  logic [sffu_pkg::WORD_W-1:0]     frame_word1,
  input  logic [sffu_pkg::WORD_W-1:0]     frame_word2,
  input  logic                            first_field,
  input  logic                            write_only,
  input  logic [sffu_pkg::LEN_W-1:0]      field_length,
  input  logic [sffu_pkg::TYPE_W-1:0]     field_type,
  input  logic [sffu_pkg::SLOT_IN_W-1:0]  counter_slot,
  output logic                            q_push,
  output sffu_pkg::item_t                 q_item,
  input  logic                            q_full
);

  localparam logic [sffu_pkg::SLOT_CODES*sffu_pkg::SLOT_IN_W-1:0] SLOT_MAP =
    sffu_pkg::slot_map(COUNTER_SLOTS);

  logic [sffu_pkg::POS_W-1:0] bit_position;
  logic [sffu_pkg::POS_W-1:0] bit_position_next;
  logic [sffu_pkg::POS_W-1:0] pos_eff;
  logic [sffu_pkg::POS_W:0]   pos_sum;
  logic                       accept;
  sffu_pkg::kind_t            kind;
  sffu_pkg::status_t          status;
  logic                       len_frac_ok;
  logic                       len_cnt_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign pos_eff = first_field ? '0 : bit_position;
  assign pos_sum = {1'b0, pos_eff} + (sffu_pkg::POS_W + 1)'(field_length);

  // write-only beats still honor the first-field restart
  always_comb begin
    bit_position_next = bit_position;
    if (accept) begin
      if (write_only) begin
        bit_position_next = pos_eff;
      end else if (pos_sum[sffu_pkg::POS_W]) begin
        bit_position_next = sffu_pkg::POS_MAX;
      end else begin
        bit_position_next = pos_sum[sffu_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position <= '0;
    end else begin
      bit_position <= bit_position_next;
    end
  end

  assign len_frac_ok = (field_length >= 7'd1) && (field_length <= 7'd32);
  assign len_cnt_ok  = (field_length >= 7'd2) && (field_length <= 7'd32);

  always_comb begin
    kind   = sffu_pkg::KIND_PLAIN;
    status = sffu_pkg::ST_OK;
    unique case (field_type)
      sffu_pkg::TYPE_BITS, sffu_pkg::TYPE_UNSIGNED,
      sffu_pkg::TYPE_STREAM, sffu_pkg::TYPE_BOOL: begin
        kind = sffu_pkg::KIND_PLAIN;
      end
      sffu_pkg::TYPE_SIGNED: begin
        if (len_frac_ok) begin
          kind = sffu_pkg::KIND_FRAC;
        end else begin
          status = sffu_pkg::ST_BAD_LEN;
        end
      end
      sffu_pkg::TYPE_COUNTER: begin
        if (len_cnt_ok) begin
          kind = sffu_pkg::KIND_COUNT;
        end else begin
          status = sffu_pkg::ST_BAD_LEN;
        end
      end
      default: begin
        status = sffu_pkg::ST_BAD_TYPE;
      end
    endcase
  end

  assign q_push        = accept && !write_only;
  assign q_item.frame  = {frame_word2, frame_word1, frame_word0};
  assign q_item.pos    = pos_eff;
  assign q_item.len    = field_length;
  assign q_item.kind   = kind;
  assign q_item.status = status;
  assign q_item.slot   = SLOT_MAP[{counter_slot, 2'b00} +: sffu_pkg::SLOT_IN_W];

  a_wo_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && write_only && !first_field) |=> bit_position == $past(bit_position))
    else $error("write-only beat moved the bit position");

endmodule

// File: src/sffu_queue.sv
// Short queue of classified field items between front and back end.
module sffu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sffu_pkg::item_t push_item,
  output logic            full,
  output logic            pop_valid,
  output sffu_pkg::item_t pop_item,
  input  logic            pop_ready
);

  localparam int DEPTH = sffu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sffu_pkg::item_t    entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue over depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

endmodule

// File: src/sffu_back.sv
// Back end: bit extraction stage, then fraction/counter update into the output register.
module sffu_back #(
  parameter int COUNTER_SLOTS = sffu_pkg::COUNTER_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  sffu_pkg::item_t               q_item,
  output logic                          q_ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sffu_pkg::RAW_W-1:0]    raw_value,
  output logic                          flag_value,
  output logic signed [sffu_pkg::CNT_W-1:0] signed_fraction,
  output logic signed [sffu_pkg::CNT_W-1:0] counter_total,
  output logic [1:0]                    status
);

  localparam int USED_SLOTS = (COUNTER_SLOTS < sffu_pkg::SLOT_CODES) ?
                              COUNTER_SLOTS : sffu_pkg::SLOT_CODES;
  localparam int SLOT_W     = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

  // extraction stage
  logic                           e_valid;
  logic [sffu_pkg::RAW_W-1:0]     e_raw;
  logic [sffu_pkg::LEN_W-1:0]     e_len;
  sffu_pkg::kind_t                e_kind;
  sffu_pkg::status_t              e_status;
  logic [SLOT_W-1:0]              e_slot;

  // output register
  logic                           o_valid;
  logic [sffu_pkg::RAW_W-1:0]     o_raw;
  logic                           o_flag;
  logic [sffu_pkg::CNT_W-1:0]     o_frac;
  logic [sffu_pkg::CNT_W-1:0]     o_total;
  sffu_pkg::status_t              o_status;

  logic [sffu_pkg::CNT_W-1:0] counter_last [USED_SLOTS];
  logic [sffu_pkg::CNT_W-1:0] counter_sum  [USED_SLOTS];

  logic o_ready, e_ready, e_load, e_move;

  logic [sffu_pkg::FRAME_W-1:0] shifted;
  logic [sffu_pkg::RAW_W-1:0]   len_mask;
  logic [sffu_pkg::RAW_W-1:0]   x_raw;

  logic [sffu_pkg::CNT_W-1:0] raw32, frac, lmask, v, last, sum, d, nd, q, span, adj;
  logic [sffu_pkg::CNT_W-1:0] new_sum;
  logic [5:0]                 frac_sh;
  logic [4:0]                 sign_idx, q_idx;

  assign o_ready = !o_valid || !out_stall;
  assign e_ready = !e_valid || o_ready;
  assign q_ready = e_ready;
  assign e_load  = q_valid && e_ready;
  assign e_move  = e_valid && o_ready;

  // LSB-first extraction; frame bits past the end read as zero
  assign shifted  = q_item.frame >> q_item.pos[6:0];
  assign len_mask = q_item.len[6] ? '1 : ~({sffu_pkg::RAW_W{1'b1}} << q_item.len[5:0]);
  assign x_raw    = (q_item.pos < 8'd96) ? (shifted[sffu_pkg::RAW_W-1:0] & len_mask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_ready) begin
      e_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      e_raw    <= x_raw;
      e_len    <= q_item.len;
      e_kind   <= q_item.kind;
      e_status <= q_item.status;
      e_slot   <= q_item.slot[SLOT_W-1:0];
    end
  end

  // Q1.31: left-justify the field (length 1..32 here)
  assign raw32   = e_raw[sffu_pkg::CNT_W-1:0];
  assign frac_sh = 6'd32 - e_len[5:0];
  assign frac    = raw32 << frac_sh[4:0];

  // counter unwrap (length 2..32 here)
  assign lmask    = e_len[5] ? '1 : ~({sffu_pkg::CNT_W{1'b1}} << e_len[4:0]);
  assign sign_idx = e_len[4:0] - 5'd1;
  assign q_idx    = e_len[4:0] - 5'd2;
  assign v        = raw32[sign_idx] ? (raw32 | ~lmask) : raw32;
  assign q        = {{(sffu_pkg::CNT_W-1){1'b0}}, 1'b1} << q_idx;
  assign span     = e_len[5] ? '0 : ({{(sffu_pkg::CNT_W-1){1'b0}}, 1'b1} << e_len[4:0]);
  assign last     = counter_last[e_slot];
  assign sum      = counter_sum[e_slot];
  assign d        = v - last;
  assign nd       = last - v;

  always_comb begin
    priority if (!d[sffu_pkg::CNT_W-1] && (d > q)) begin
      adj = -span;
    end else if (!nd[sffu_pkg::CNT_W-1] && (nd > q)) begin
      adj = span;
    end else begin
      adj = '0;
    end
  end

  assign new_sum = sum + d + adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USED_SLOTS; i++) begin
        counter_last[i] <= '0;
        counter_sum[i]  <= '0;
      end
    end else if (e_move && (e_kind == sffu_pkg::KIND_COUNT)) begin
      counter_last[e_slot] <= v;
      counter_sum[e_slot]  <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= e_move || (o_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (e_move) begin
      o_raw    <= e_raw;
      o_flag   <= |e_raw;
      o_frac   <= (e_kind == sffu_pkg::KIND_FRAC)  ? frac    : '0;
      o_total  <= (e_kind == sffu_pkg::KIND_COUNT) ? new_sum : '0;
      o_status <= e_status;
    end
  end

  assign out_valid       = o_valid;
  assign raw_value       = o_raw;
  assign flag_value      = o_flag;
  assign signed_fraction = o_frac;
  assign counter_total   = o_total;
  assign status          = o_status;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && (o_status != sffu_pkg::ST_OK)) |-> (o_frac == '0 && o_total == '0))
    else $error("flagged beat carries fraction or total");

endmodule
